/* sv/cfc_pkg.sv */
// shared types and constants for the chunk frustum cull block
// no dependencies; imported by every cfc module and the top level
package cfc_pkg;

  localparam int MAX_CHUNKS  = 1024;
  localparam int PLANE_COUNT = 6;
  localparam int AXES        = 3;

  // chunk counter saturates at min(MAX_CHUNKS, 2047)
  localparam logic [10:0] CHUNK_CAP = 11'((MAX_CHUNKS > 2047) ? 2047 : MAX_CHUNKS);
  localparam logic [23:0] TRI_CAP   = 24'hFF_FFFF;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_MATRIX_COL0 = 2'd0;
  localparam logic [1:0] CFG_MATRIX_COL1 = 2'd1;
  localparam logic [1:0] CFG_MATRIX_COL2 = 2'd2;
  localparam logic [1:0] CFG_MATRIX_COL3 = 2'd3;

  // identity matrix in Q8.8, one column per register
  localparam logic [63:0] MATRIX_COL0_RESET = 64'h0000_0000_0000_0100;
  localparam logic [63:0] MATRIX_COL1_RESET = 64'h0000_0000_0100_0000;
  localparam logic [63:0] MATRIX_COL2_RESET = 64'h0000_0100_0000_0000;
  localparam logic [63:0] MATRIX_COL3_RESET = 64'h0100_0000_0000_0000;

  // classified chunk as it travels from front to back
  typedef struct packed {
    logic        visible;
    logic [13:0] triangles;
    logic        frame_start;
  } item_t;

endpackage

/* sv/cfc_front.sv */
// front end: camera matrix registers, plane derivation and two-stage box test
// depends on cfc_pkg; feeds cfc_queue
module cfc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    min_x,
  input  logic signed [15:0]    min_y,
  input  logic signed [15:0]    min_z,
  input  logic signed [15:0]    max_x,
  input  logic signed [15:0]    max_y,
  input  logic signed [15:0]    max_z,
  input  logic [13:0]           chunk_triangles,
  input  logic                  frame_start,
  input  logic [cfc_pkg::QCNT_W-1:0] q_count,
  output logic                  push,
  output cfc_pkg::item_t        push_item
);
  import cfc_pkg::*;

  logic [63:0] matrix [4];

  logic signed [16:0] coef [PLANE_COUNT][4];
  logic signed [32:0] prod_c [PLANE_COUNT][AXES];
  logic signed [15:0] bmin [AXES];
  logic signed [15:0] bmax [AXES];
  logic signed [34:0] acc [PLANE_COUNT];
  logic               all_in;

  // stage 1 registers
  logic               s1_valid;
  logic signed [32:0] prod [PLANE_COUNT][AXES];
  logic signed [20:0] plane_off [PLANE_COUNT];
  logic [13:0]        s1_tris;
  logic               s1_fs;

  // stage 2 registers
  logic               s2_valid;
  item_t              s2_item;

  logic [QCNT_W:0]    occupancy;
  logic               accept;

  // matrix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix[CFG_MATRIX_COL0] <= MATRIX_COL0_RESET;
      matrix[CFG_MATRIX_COL1] <= MATRIX_COL1_RESET;
      matrix[CFG_MATRIX_COL2] <= MATRIX_COL2_RESET;
      matrix[CFG_MATRIX_COL3] <= MATRIX_COL3_RESET;
    end else if (cfg_write) begin
      matrix[cfg_index] <= cfg_data;
    end
  end

  // plane 2k = row3 + row k, plane 2k+1 = row3 - row k
  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int a = 0; a < 4; a++) begin
        if (p[0]) begin
          coef[p][a] = 17'(signed'(matrix[a][63:48])) - 17'(signed'(matrix[a][16*(p/2) +: 16]));
        end else begin
          coef[p][a] = 17'(signed'(matrix[a][63:48])) + 17'(signed'(matrix[a][16*(p/2) +: 16]));
        end
      end
    end
  end

  assign bmin[0] = min_x;
  assign bmin[1] = min_y;
  assign bmin[2] = min_z;
  assign bmax[0] = max_x;
  assign bmax[1] = max_y;
  assign bmax[2] = max_z;

  // positive vertex per axis, then one product per plane and axis
  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int a = 0; a < AXES; a++) begin
        if (coef[p][a][16]) begin
          prod_c[p][a] = coef[p][a] * bmin[a];
        end else begin
          prod_c[p][a] = coef[p][a] * bmax[a];
        end
      end
    end
  end

  // credit check: queue entries plus items still in the pipe
  assign occupancy = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid)
                   + (QCNT_W + 1)'(s2_valid);
  assign in_ready  = occupancy < (QCNT_W + 1)'(Q_DEPTH);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= prod_c;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      plane_off[p] <= {coef[p][3], 4'b0000};
    end
    s1_tris <= chunk_triangles;
    s1_fs   <= frame_start;
  end

  // per-plane sum and sign test
  always_comb begin
    all_in = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      acc[p] = 35'(prod[p][0]) + 35'(prod[p][1]) + 35'(prod[p][2]) + 35'(plane_off[p]);
      if (acc[p][34]) begin
        all_in = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_item.visible     <= all_in;
    s2_item.triangles   <= s1_tris;
    s2_item.frame_start <= s1_fs;
  end

  assign push      = s2_valid;
  assign push_item = s2_item;

endmodule

/* sv/cfc_queue.sv */
// short flop queue between the classifying front and the counting back
// depends on cfc_pkg
module cfc_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  cfc_pkg::item_t             push_item,
  input  logic                       pop,
  output logic                       not_empty,
  output cfc_pkg::item_t             head,
  output logic [cfc_pkg::QCNT_W-1:0] count
);
  import cfc_pkg::*;

  item_t             entries [Q_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic              do_pop;

  assign not_empty = count != '0;
  assign head      = entries[rptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

endmodule

/* sv/cfc_back.sv */
// back end: per-frame running totals and the output register
// depends on cfc_pkg; drains cfc_queue
module cfc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_not_empty,
  input  cfc_pkg::item_t q_head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           visible,
  output logic [10:0]    chunks_drawn,
  output logic [23:0]    triangles_drawn
);
  import cfc_pkg::*;

  logic [10:0] chunk_total;
  logic [23:0] tri_total;
  logic [10:0] chunk_base;
  logic [23:0] tri_base;
  logic [10:0] chunk_total_next;
  logic [23:0] tri_total_next;
  logic [24:0] tri_sum;

  assign pop = q_not_empty && (!out_valid || out_ready);

  always_comb begin
    chunk_base = q_head.frame_start ? '0 : chunk_total;
    tri_base   = q_head.frame_start ? '0 : tri_total;
    tri_sum    = {1'b0, tri_base} + 25'(q_head.triangles);
    chunk_total_next = chunk_base;
    tri_total_next   = tri_base;
    if (q_head.visible) begin
      if (chunk_base < CHUNK_CAP) begin
        chunk_total_next = chunk_base + 11'd1;
      end
      if (tri_sum > {1'b0, TRI_CAP}) begin
        tri_total_next = TRI_CAP;
      end else begin
        tri_total_next = tri_sum[23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_total <= '0;
      tri_total   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        chunk_total <= chunk_total_next;
        tri_total   <= tri_total_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      visible         <= q_head.visible;
      chunks_drawn    <= chunk_total_next;
      triangles_drawn <= tri_total_next;
    end
  end

endmodule

/* sv/chunk_frustum_cull_top.sv */
// top level of the chunk frustum cull block
// depends on cfc_pkg, cfc_front, cfc_queue and cfc_back
//
// usage:
// - configuration: cfg_write/cfg_index/cfg_data load one 64-bit matrix column
//   per write (four signed Q8.8 entries, row 0 in the low bits); write only
//   while no transaction is in flight
// - input channel: in_valid/in_ready; one transaction carries one chunk box
//   (Q12.4 corners), its triangle count and a frame-start flag
// - output channel: out_valid/out_ready; one transaction per input carrying
//   the visibility bit and the running per-frame totals after this chunk
// - throughput: one chunk per cycle while out_ready is high; the six plane tests
//   are fully parallel and only the running-total add carries from item to item
// - result path: multiply stage, plane-sum stage, queue slot, then the output
//   register, whose load raises out_valid
// - a four-entry queue separates the plane test from the totals, so the
//   front keeps accepting while a result waits; in_ready drops only once the
//   queue plus the two test stages hold four chunks
// - receiver stall: results stay in the output register and queue; nothing
//   is dropped and in_ready falls when the queue runs out of credit
// - reset (synchronous, active high): matrix returns to identity, totals to
//   zero, queue and pipe empty
module chunk_frustum_cull_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] min_x,
  input  logic signed [15:0] min_y,
  input  logic signed [15:0] min_z,
  input  logic signed [15:0] max_x,
  input  logic signed [15:0] max_y,
  input  logic signed [15:0] max_z,
  input  logic [13:0]        chunk_triangles,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               visible,
  output logic [10:0]        chunks_drawn,
  output logic [23:0]        triangles_drawn
);
  import cfc_pkg::*;

  logic              push;
  item_t             push_item;
  logic              pop;
  logic              q_not_empty;
  item_t             q_head;
  logic [QCNT_W-1:0] q_count;

  // plane test and classification
  cfc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .min_x           (min_x),
    .min_y           (min_y),
    .min_z           (min_z),
    .max_x           (max_x),
    .max_y           (max_y),
    .max_z           (max_z),
    .chunk_triangles (chunk_triangles),
    .frame_start     (frame_start),
    .q_count         (q_count),
    .push            (push),
    .push_item       (push_item)
  );

  // decoupling queue
  cfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .count     (q_count)
  );

  // running totals and result register
  cfc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .visible         (visible),
    .chunks_drawn    (chunks_drawn),
    .triangles_drawn (triangles_drawn)
  );

endmodule

/* verif/tb_chunk_frustum_cull_top.sv */
// self-checking testbench for chunk_frustum_cull_top: box culling against six camera planes
// depends on cfc_pkg and chunk_frustum_cull_top; predicts visibility and per-frame totals
// and compares every output transaction against them
module tb_chunk_frustum_cull_top;
  import cfc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 400;

  // one chunk box as offered on the input channel
  typedef struct packed {
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] min_z;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic signed [15:0] max_z;
    logic [13:0]        tris;
    logic               frame_start;
  } chunk_box_t;

  // what the block should report for one chunk
  typedef struct packed {
    logic        visible;
    logic [10:0] chunks;
    logic [23:0] tris;
  } cull_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // clock and block ports; the inputs that the bench drives are known from time zero
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = CFG_MATRIX_COL0;
  logic [63:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] min_x = '0;
  logic signed [15:0] min_y = '0;
  logic signed [15:0] min_z = '0;
  logic signed [15:0] max_x = '0;
  logic signed [15:0] max_y = '0;
  logic signed [15:0] max_z = '0;
  logic [13:0]        chunk_triangles = '0;
  logic               frame_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               visible;
  logic [10:0]        chunks_drawn;
  logic [23:0]        triangles_drawn;

  // predictor copy of the camera matrix and the frame totals
  logic [63:0]  camera_cols [4] = '{MATRIX_COL0_RESET, MATRIX_COL1_RESET,
                                    MATRIX_COL2_RESET, MATRIX_COL3_RESET};
  logic [10:0]  chunk_total = '0;
  logic [23:0]  tri_total = '0;

  chunk_box_t   box_backlog [$];   // boxes waiting for the driver
  cull_result_t results_due [$];   // predicted results, oldest first
  chunk_box_t   cur_box;           // box currently on the input port

  int  boxes_queued = 0;
  int  boxes_accepted = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  offer_taken = 1'b0;
  bit  steady = 1'b0;              // sender offers back to back when set
  int  burst_left = 0;
  int  gap_left = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  mode_left = 0;
  rx_mode_t   rx_mode = RX_OPEN;
  logic [7:0] rx_pattern = 8'hA5;

  chunk_frustum_cull_top DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .min_x           (min_x),
    .min_y           (min_y),
    .min_z           (min_z),
    .max_x           (max_x),
    .max_y           (max_y),
    .max_z           (max_z),
    .chunk_triangles (chunk_triangles),
    .frame_start     (frame_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .visible         (visible),
    .chunks_drawn    (chunks_drawn),
    .triangles_drawn (triangles_drawn)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // plane test plus frame totals for one accepted chunk; updates the totals
  function automatic cull_result_t cull_chunk(chunk_box_t b);
    logic signed [15:0] lo [3];
    logic signed [15:0] hi [3];
    logic signed [15:0] w_ent;
    logic signed [15:0] k_ent;
    logic signed [17:0] coef [4];
    logic signed [15:0] corner;
    longint             acc;
    int                 k;
    int                 tri_sum;
    cull_result_t       r;
    lo[0] = b.min_x;
    lo[1] = b.min_y;
    lo[2] = b.min_z;
    hi[0] = b.max_x;
    hi[1] = b.max_y;
    hi[2] = b.max_z;
    // frame start clears the totals before this chunk counts
    if (b.frame_start) begin
      chunk_total = '0;
      tri_total = '0;
    end
    r.visible = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      k = p / 2;
      // plane 2k is row3 + row k, plane 2k+1 is row3 - row k
      for (int a = 0; a < 4; a++) begin
        w_ent = camera_cols[a][63:48];
        k_ent = camera_cols[a][16*k +: 16];
        coef[a] = (p % 2 == 1) ? w_ent - k_ent : w_ent + k_ent;
      end
      // distance is Q.8, corner products are Q.12
      acc = longint'(coef[3]) * 16;
      for (int a = 0; a < AXES; a++) begin
        // positive vertex: max corner when the normal component is not negative
        corner = (coef[a] >= 0) ? hi[a] : lo[a];
        acc += longint'(coef[a]) * longint'(corner);
      end
      if (acc < 0) r.visible = 1'b0;
    end
    if (r.visible) begin
      if (chunk_total < CHUNK_CAP) chunk_total = chunk_total + 11'd1;
      tri_sum = int'(tri_total) + int'(b.tris);
      tri_total = (tri_sum > int'(TRI_CAP)) ? TRI_CAP : tri_sum[23:0];
    end
    r.chunks = chunk_total;
    r.tris = tri_total;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] sat16(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // random signed Q8.8 entry in [lo, hi]
  function automatic logic [15:0] q88(int lo, int hi);
    int v;
    v = int'($urandom_range(hi - lo, 0)) + lo;
    return v[15:0];
  endfunction

  function automatic logic [1:0] col_reg(int i);
    case (i)
      0:       return CFG_MATRIX_COL0;
      1:       return CFG_MATRIX_COL1;
      2:       return CFG_MATRIX_COL2;
      default: return CFG_MATRIX_COL3;
    endcase
  endfunction

  // camera-like column: strong diagonal, small skew, positive w distance
  function automatic logic [63:0] camera_col(int c);
    logic [63:0] col;
    for (int r = 0; r < 4; r++) begin
      if (r == c && r < 3) col[16*r +: 16] = q88(64, 1024);
      else if (r == 3 && c == 3) col[16*r +: 16] = q88(256, 2048);
      else if (c == 3) col[16*r +: 16] = q88(-512, 512);
      else col[16*r +: 16] = q88(-64, 64);
    end
    return col;
  endfunction

  function automatic chunk_box_t random_box();
    chunk_box_t b;
    int lo [3];
    int hi [3];
    int pick;
    int span;
    int c;
    int e;
    int ax;
    int t;
    pick = $urandom_range(19, 0);
    case ($urandom_range(2, 0))
      0:       span = 128;
      1:       span = 2048;
      default: span = 65535;
    endcase
    for (int a = 0; a < AXES; a++) begin
      c = int'($urandom_range(span, 0)) - span / 2;
      e = $urandom_range((span <= 128) ? 64 : 512, 0);
      lo[a] = c - e;
      hi[a] = c + e;
    end
    // swapped corners on one axis
    if (pick >= 17) begin
      ax = $urandom_range(2, 0);
      t = lo[ax];
      lo[ax] = hi[ax];
      hi[ax] = t;
    end
    b.min_x = sat16(lo[0]);
    b.min_y = sat16(lo[1]);
    b.min_z = sat16(lo[2]);
    b.max_x = sat16(hi[0]);
    b.max_y = sat16(hi[1]);
    b.max_z = sat16(hi[2]);
    // raw noise on every corner field
    if (pick < 3) begin
      b.min_x = 16'($urandom);
      b.min_y = 16'($urandom);
      b.min_z = 16'($urandom);
      b.max_x = 16'($urandom);
      b.max_y = 16'($urandom);
      b.max_z = 16'($urandom);
    end
    b.tris = ($urandom_range(3, 0) == 0) ? 14'($urandom_range(16383, 0))
                                         : 14'($urandom_range(8192, 0));
    b.frame_start = ($urandom_range(24, 0) == 0);
    return b;
  endfunction

  task automatic queue_box(chunk_box_t b);
    box_backlog = {box_backlog, b};
    boxes_queued++;
  endtask

  task automatic push_box(int mnx, int mny, int mnz, int mxx, int mxy, int mxz,
                          int tris, int fs);
    chunk_box_t b;
    b.min_x = mnx[15:0];
    b.min_y = mny[15:0];
    b.min_z = mnz[15:0];
    b.max_x = mxx[15:0];
    b.max_y = mxy[15:0];
    b.max_z = mxz[15:0];
    b.tris = tris[13:0];
    b.frame_start = fs[0];
    queue_box(b);
  endtask

  task automatic run_random(int count);
    repeat (count) queue_box(random_box());
  endtask

  // four back-to-back column writes, enable low only after the last
  task automatic load_matrix(input logic [63:0] c0, c1, c2, c3);
    logic [63:0] cols [4];
    cols = '{c0, c1, c2, c3};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= col_reg(i);
      cfg_data <= cols[i];
      camera_cols[i] = cols[i];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_camera();
    load_matrix(camera_col(0), camera_col(1), camera_col(2), camera_col(3));
  endtask

  // sender pause: everything accepted and every result back, plus the pipe tail
  task automatic wait_idle();
    while (boxes_accepted != boxes_queued || results_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: input channel, changes at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || offer_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (box_backlog.size() > 0) begin
        cur_box = box_backlog.pop_front();
        min_x <= cur_box.min_x;
        min_y <= cur_box.min_y;
        min_z <= cur_box.min_z;
        max_x <= cur_box.max_x;
        max_y <= cur_box.max_y;
        max_z <= cur_box.max_z;
        chunk_triangles <= cur_box.tris;
        frame_start <= cur_box.frame_start;
        in_valid <= 1'b1;
        // bursts of random length separated by random gaps unless steady is set
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(12, 1);
          gap_left = steady ? 0 : $urandom_range(6, 1);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
    offer_taken = 1'b0;
  end

  // input monitor: an accepted transaction gets its prediction right away
  always @(posedge clk) begin
    cull_result_t due;
    if (!rst && in_valid && in_ready) begin
      due = cull_chunk(cur_box);
      results_due = {results_due, due};
      boxes_accepted++;
      offer_taken = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern of its own, plus the long hold on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(2, 0));
      mode_left = $urandom_range(96, 16);
      rx_pattern = 8'($urandom);
      rx_pattern[0] = 1'b1;
    end else begin
      mode_left--;
      rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(9, 0) > 2);
        default:   out_ready <= rx_pattern[0];
      endcase
    end
  end

  // output monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    cull_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing pending, visible", visible, 0);
      end else begin
        want = results_due.pop_front();
        if (visible !== want.visible) report_mismatch("visible", visible, want.visible);
        if (chunks_drawn !== want.chunks)
          report_mismatch("chunks_drawn", chunks_drawn, want.chunks);
        if (triangles_drawn !== want.tris)
          report_mismatch("triangles_drawn", triangles_drawn, want.tris);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed boxes against the reset identity matrix, where 1.0 is 16 raw
    steady = 1'b1;
    push_box(-8, -8, -8, 8, 8, 8, 100, 1);                       // well inside
    push_box(-32768, -32768, -32768, 32767, 32767, 32767, 16383, 0); // covers all
    push_box(32767, 32767, 32767, 32767, 32767, 32767, 50, 0);   // far corner
    push_box(-32768, -32768, -32768, -32768, -32768, -32768, 50, 0);
    push_box(16, 0, 0, 16, 0, 0, 7, 0);                          // on the +x plane
    push_box(17, 0, 0, 17, 0, 0, 7, 0);                          // just past +x
    push_box(-16, 0, 0, -16, 0, 0, 3, 0);                        // on the -x plane
    push_box(-17, 0, 0, -17, 0, 0, 3, 0);
    push_box(0, 16, 0, 0, 16, 0, 1, 0);
    push_box(0, 0, -16, 0, 0, -16, 1, 0);
    push_box(0, 100, 0, 0, 120, 0, 9, 0);                        // outside +y
    push_box(0, 0, -120, 0, 0, -100, 9, 0);                      // outside -z
    push_box(100, -8, -8, -100, 8, 8, 11, 0);                    // swapped wide x
    push_box(8, -8, -8, -8, 8, 8, 0, 0);                         // swapped narrow x
    push_box(-4, 8, -4, 4, -8, 4, 8192, 0);                      // swapped y
    push_box(-4, -4, 8, 4, 4, -8, 8193, 0);                      // swapped z, count over 8192
    push_box(500, 500, 500, 600, 600, 600, 5, 1);                // new frame, invisible
    push_box(-20, -20, -20, 20, 20, 20, 16383, 0);               // crossing all planes
    push_box(21845, -21846, 21845, -21846, 21845, -21846, 10922, 1);
    push_box(-21846, 21845, -21846, 21845, -21846, 21845, 5461, 0);
    wait_idle();

    // camera-like matrix; receiver holds off long so the block backs up
    steady = 1'b0;
    load_camera();
    hold_req++;
    run_random(60);
    wait_idle();

    // most negative entries everywhere
    load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    run_random(20);
    wait_idle();

    // full random matrix
    load_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom});
    steady = 1'b1;
    run_random(40);
    wait_idle();

    // most positive entries everywhere
    steady = 1'b0;
    load_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
    run_random(20);
    wait_idle();

    // zero matrix: every plane sum is exactly zero, so every box passes
    load_matrix(64'h0, 64'h0, 64'h0, 64'h0);
    run_random(10);
    wait_idle();

    // one long frame where every box passes and counts are high, so both
    // running totals reach their caps
    load_matrix(64'h0, 64'h0, 64'h0, {16'h7FFF, 48'h0});
    for (int i = 0; i < 1040; i++) begin
      chunk_box_t b;
      b = random_box();
      b.frame_start = (i == 0);
      b.tris = 14'($urandom_range(16383, 16200));
      queue_box(b);
    end
    wait_idle();

    // back to a camera matrix with another long receiver hold
    load_camera();
    hold_req++;
    run_random(30);
    wait_idle();

    repeat (10) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch("results never delivered", 0, results_due.size());
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
